// ----- hw/rtl/nfba_pkg.sv -----
// Shared types, codes and constants for the next-fit block allocator.
`timescale 1ns / 1ps

package nfba_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int HEADER_BYTES   = 16;

    localparam int OFF_W  = 29;
    localparam int ADDR_W = 32;
    localparam int NEED_W = 30;

    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [OFF_W-1:0] POOL_RESET = 29'd16777216;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_OOM     = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL = 1'b1;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [OFF_W-1:0] size;
        logic             used;
    } entry_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] address;
    } res_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ALLOC_SCAN,
        ST_ALLOC_WRITE,
        ST_SPLIT_WRITE,
        ST_REL_SCAN,
        ST_CLEAR,
        ST_DONE
    } state_t;

endpackage

// ----- hw/rtl/next_fit_block_allocator.sv -----
// Top level of the next-fit block allocator with configuration and output registers.
// An allocate scans table entries from the next-fit start, at most MAX_BLOCKS of them,
// writes the chosen entry and, when the block is split, one more entry; release scans
// from entry 0; pool reset rewrites block 0; an unused command only returns a result.
// One word is in work at a time; block 0 is written in the init state after reset,
// during which no word is accepted, and holds one free block of 16777216 bytes.
`timescale 1ns / 1ps

module next_fit_block_allocator #(
    parameter int MAX_BLOCKS = nfba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // request_bytes[28:0], release_address[60:29], zero fill above
    input  logic [nfba_pkg::IN_DATA_W-1:0]      s_tdata,
    // cmd[1:0]
    input  logic [nfba_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status[1:0], address[33:2], zero fill above
    output logic [nfba_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_we,
    input  logic [nfba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nfba_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import nfba_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);

    logic [ADDR_W-1:0] base_reg;
    logic [OFF_W-1:0]  pool_reg;
    logic              m_tvalid_reg;
    res_t              out_reg;

    logic              res_valid;
    logic              res_ready;
    res_t              res;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    entry_t            mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    entry_t            mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            pool_reg <= POOL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASE: base_reg <= cfg_data;
                CFG_POOL: pool_reg <= cfg_data[OFF_W-1:0];
                default:  ;
            endcase
        end
    end

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_DATA_W - ADDR_W - 2)'(0), out_reg.address, out_reg.status};

    nfba_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_cmd       (s_tuser),
        .in_req       (s_tdata[OFF_W-1:0]),
        .in_rel       (s_tdata[OFF_W+ADDR_W-1:OFF_W]),
        .base_address (base_reg),
        .pool_bytes   (pool_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    nfba_table #(
        .DEPTH (MAX_BLOCKS),
        .AW    (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ----- hw/rtl/nfba_table.sv -----
// Block table memory with one write port and one registered read port.
`timescale 1ns / 1ps

module nfba_table #(
    parameter int DEPTH = nfba_pkg::MAX_BLOCKS_DEF,
    parameter int AW    = $clog2(nfba_pkg::MAX_BLOCKS_DEF)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  nfba_pkg::entry_t wdata,
    input  logic [AW-1:0]    raddr,
    output nfba_pkg::entry_t rdata
);
    import nfba_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/nfba_ctrl.sv -----
// Command sequencer that scans, updates and splits entries of the block table.
`timescale 1ns / 1ps

module nfba_ctrl #(
    parameter int MAX_BLOCKS = nfba_pkg::MAX_BLOCKS_DEF,
    parameter int IDX_W      = $clog2(nfba_pkg::MAX_BLOCKS_DEF)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  in_cmd,
    input  logic [nfba_pkg::OFF_W-1:0]  in_req,
    input  logic [nfba_pkg::ADDR_W-1:0] in_rel,
    input  logic [nfba_pkg::ADDR_W-1:0] base_address,
    input  logic [nfba_pkg::OFF_W-1:0]  pool_bytes,
    output logic                        res_valid,
    input  logic                        res_ready,
    output nfba_pkg::res_t              res,
    output logic                        mem_we,
    output logic [IDX_W-1:0]            mem_waddr,
    output nfba_pkg::entry_t            mem_wdata,
    output logic [IDX_W-1:0]            mem_raddr,
    input  nfba_pkg::entry_t            mem_rdata
);
    import nfba_pkg::*;

    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);
    localparam logic [NEED_W:0]  HDR_W31 = (NEED_W + 1)'(HEADER_BYTES);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    start_reg, start_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic [CNT_W-1:0]    visit_reg, visit_next;
    logic [NEED_W-1:0]   need_reg, need_next;
    logic [ADDR_W-1:0]   rel_reg, rel_next;
    entry_t              hit_reg, hit_next;
    logic [OFF_W-1:0]    end_reg, end_next;
    res_t                res_reg, res_next;

    logic [CNT_W-1:0]    cur_inc;
    logic [IDX_W-1:0]    next_idx;
    logic [NEED_W-1:0]   in_need;
    logic                scan_fit;
    logic                scan_last;
    logic [ADDR_W-1:0]   scan_addr;
    logic [ADDR_W-1:0]   grant_addr;
    logic [NEED_W:0]     end_sum;
    logic [NEED_W:0]     need_hdr;
    logic                split_ok;
    logic [OFF_W-1:0]    split_size;

    assign cur_inc    = {1'b0, cur_reg} + CNT_W'(1);
    assign next_idx   = (cur_inc >= count_reg) ? '0 : cur_inc[IDX_W-1:0];
    assign in_need    = ({1'b0, in_req} + NEED_W'(3)) & ~NEED_W'(3);
    assign scan_fit   = !mem_rdata.used && ({1'b0, mem_rdata.size} >= need_reg);
    assign scan_last  = (visit_reg + CNT_W'(1)) == count_reg;
    assign scan_addr  = base_address + {3'b000, mem_rdata.offset} + ADDR_W'(HEADER_BYTES);
    assign grant_addr = base_address + {3'b000, hit_reg.offset} + ADDR_W'(HEADER_BYTES);
    assign end_sum    = {2'b00, hit_reg.offset} + {1'b0, need_reg} + HDR_W31;
    assign need_hdr   = {1'b0, need_reg} + HDR_W31;
    assign split_ok   = (cur_inc == count_reg) && (end_sum < {2'b00, pool_bytes})
                        && ({2'b00, hit_reg.size} >= need_hdr) && (count_reg < MAX_CNT);
    assign split_size = hit_reg.size - need_reg[OFF_W-1:0] - OFF_W'(HEADER_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            count_reg <= CNT_W'(1);
            start_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            start_reg <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        visit_reg <= visit_next;
        need_reg  <= need_next;
        rel_reg   <= rel_next;
        hit_reg   <= hit_next;
        end_reg   <= end_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        start_next = start_reg;
        cur_next   = cur_reg;
        visit_next = visit_reg;
        need_next  = need_reg;
        rel_next   = rel_reg;
        hit_next   = hit_reg;
        end_next   = end_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = cur_reg;
        mem_wdata  = mem_rdata;
        mem_raddr  = next_idx;
        in_ready   = 1'b0;
        res_valid  = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = entry_t'{offset: '0, size: POOL_RESET, used: 1'b0};
                state_next = ST_IDLE;
            end

            ST_IDLE:
            begin
                in_ready   = 1'b1;
                mem_raddr  = (in_cmd == CMD_ALLOC) ? start_reg : '0;
                if (in_valid)
                begin
                    visit_next = '0;
                    need_next  = in_need;
                    rel_next   = in_rel;
                    res_next   = res_t'{status: STATUS_OK, address: '0};
                    case (in_cmd)
                        CMD_ALLOC:
                        begin
                            cur_next   = start_reg;
                            state_next = ST_ALLOC_SCAN;
                        end
                        CMD_RELEASE:
                        begin
                            cur_next   = '0;
                            state_next = ST_REL_SCAN;
                        end
                        CMD_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_ALLOC_SCAN:
            begin
                if (scan_fit)
                begin
                    hit_next   = mem_rdata;
                    state_next = ST_ALLOC_WRITE;
                end
                else if (scan_last)
                begin
                    res_next   = res_t'{status: STATUS_OOM, address: '0};
                    state_next = ST_CLEAR;
                end
                else
                begin
                    cur_next   = next_idx;
                    visit_next = visit_reg + CNT_W'(1);
                end
            end

            ST_ALLOC_WRITE:
            begin
                mem_we     = 1'b1;
                mem_wdata  = entry_t'{offset: hit_reg.offset,
                                      size: split_ok ? need_reg[OFF_W-1:0] : hit_reg.size,
                                      used: 1'b1};
                end_next   = end_sum[OFF_W-1:0];
                res_next   = res_t'{status: STATUS_OK, address: grant_addr};
                if (split_ok)
                begin
                    state_next = ST_SPLIT_WRITE;
                end
                else
                begin
                    if (cur_inc < count_reg)
                    begin
                        start_next = cur_inc[IDX_W-1:0];
                    end
                    state_next = ST_DONE;
                end
            end

            ST_SPLIT_WRITE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = count_reg[IDX_W-1:0];
                mem_wdata  = entry_t'{offset: end_reg, size: split_size, used: 1'b0};
                count_next = count_reg + CNT_W'(1);
                start_next = cur_inc[IDX_W-1:0];
                state_next = ST_DONE;
            end

            ST_REL_SCAN:
            begin
                if (scan_addr == rel_reg)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = entry_t'{offset: mem_rdata.offset, size: mem_rdata.size,
                                          used: 1'b0};
                    state_next = ST_DONE;
                end
                else if (scan_last)
                begin
                    res_next   = res_t'{status: STATUS_UNKNOWN, address: '0};
                    state_next = ST_DONE;
                end
                else
                begin
                    cur_next   = next_idx;
                    visit_next = visit_reg + CNT_W'(1);
                end
            end

            ST_CLEAR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = entry_t'{offset: '0, size: pool_bytes, used: 1'b0};
                count_next = CNT_W'(1);
                start_next = '0;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

// ----- hw/rtl/nfba_checker.sv -----
// Port-level checks for the next-fit block allocator and their binding.
`timescale 1ns / 1ps

module nfba_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [nfba_pkg::OUT_DATA_W-1:0] m_tdata
);
    import nfba_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result word changed or dropped while stalled.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("Result carries an undefined status code.");

    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == STATUS_OOM || m_tdata[1:0] == STATUS_UNKNOWN)
        |-> m_tdata[ADDR_W+1:2] == '0)
        else $error("Failed command returned a nonzero address.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Word accepted while the previous command was still in work.");

endmodule

bind next_fit_block_allocator nfba_checker u_nfba_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- dv/next_fit_block_allocator_test.sv -----
// Self-checking testbench for the next-fit block allocator with a built-in table predictor.
`timescale 1ns / 1ps

module next_fit_block_allocator_test;
    import nfba_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 143;
    localparam int SCRIPT_ROWS = 20;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [28:0] req;
        logic [31:0] rel;
        logic        typed;
        logic [1:0]  status;
        logic [31:0] address;
    } script_row_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data  = '0;

    logic [28:0] blk_off  [MAX_BLOCKS_DEF];
    logic [28:0] blk_size [MAX_BLOCKS_DEF];
    logic        blk_used [MAX_BLOCKS_DEF];
    int          blk_count;
    int          next_start;
    logic [31:0] cfg_base;
    logic [28:0] cfg_pool;

    res_t        replies_due [$];
    logic [31:0] granted [$];
    script_row_t script [SCRIPT_ROWS];
    res_t        head;
    int          faults = 0;
    int          cycles = 0;
    int          stall_left = 0;
    bit          calm = 1'b0;

    next_fit_block_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void clear_table();
        blk_off[0]  = '0;
        blk_size[0] = cfg_pool;
        blk_used[0] = 1'b0;
        blk_count   = 1;
        next_start  = 0;
    endfunction

    function automatic res_t run_allocator(input logic [1:0] cmd, input logic [28:0] req,
                                           input logic [31:0] rel);
        res_t        r;
        logic [31:0] need;
        logic [63:0] tail_end;
        int          idx;
        int          n;
        bit          hit;
        r.status  = STATUS_OK;
        r.address = '0;
        hit       = 1'b0;
        if (cmd == CMD_ALLOC)
        begin
            need = ({3'b0, req} + 32'd3) & ~32'd3;
            idx  = next_start;
            for (n = 0; n < blk_count && !hit; n++)
            begin
                if (!blk_used[idx] && {3'b0, blk_size[idx]} >= need)
                    hit = 1'b1;
                else
                    idx = (idx + 1 >= blk_count) ? 0 : idx + 1;
            end
            if (!hit)
            begin
                clear_table();
                r.status = STATUS_OOM;
            end
            else
            begin
                blk_used[idx] = 1'b1;
                if (idx + 1 == blk_count)
                begin
                    tail_end = 64'(blk_off[idx]) + 64'(need) + 64'(HEADER_BYTES);
                    if (tail_end < 64'(cfg_pool) &&
                        {3'b0, blk_size[idx]} >= need + 32'(HEADER_BYTES) &&
                        blk_count < MAX_BLOCKS_DEF)
                    begin
                        blk_off[blk_count]  = tail_end[28:0];
                        blk_size[blk_count] = 29'({3'b0, blk_size[idx]} - need
                                                  - 32'(HEADER_BYTES));
                        blk_used[blk_count] = 1'b0;
                        blk_size[idx]       = need[28:0];
                        blk_count           = blk_count + 1;
                    end
                end
                if (idx + 1 < blk_count)
                    next_start = idx + 1;
                r.address = cfg_base + {3'b0, blk_off[idx]} + 32'(HEADER_BYTES);
            end
        end
        else if (cmd == CMD_RELEASE)
        begin
            r.status = STATUS_UNKNOWN;
            for (n = 0; n < blk_count && !hit; n++)
            begin
                if (cfg_base + {3'b0, blk_off[n]} + 32'(HEADER_BYTES) == rel)
                begin
                    blk_used[n] = 1'b0;
                    r.status    = STATUS_OK;
                    hit         = 1'b1;
                end
            end
        end
        else if (cmd == CMD_CLEAR)
        begin
            clear_table();
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_word(input logic [1:0] cmd, input logic [28:0] req,
                             input logic [31:0] rel, input bit typed, input res_t typed_reply);
        int   gap;
        res_t reply;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b0, rel, req};
        do
            @(posedge clk);
        while (!s_tready);
        reply = run_allocator(cmd, req, rel);
        replies_due.push_back(typed ? typed_reply : reply);
        if (cmd == CMD_ALLOC && reply.status == STATUS_OK)
        begin
            granted.push_back(reply.address);
            if (granted.size() > 200)
                void'(granted.pop_front());
        end
    endtask

    task automatic random_word();
        logic [1:0]  cmd;
        logic [28:0] req;
        logic [31:0] rel;
        int          pick;
        int          k;
        int          j;
        res_t        blank;
        blank = '0;
        pick  = $urandom_range(0, 99);
        k     = $urandom_range(0, 99);
        req   = 29'($urandom);
        rel   = $urandom;
        if (pick < 52)
        begin
            cmd = CMD_ALLOC;
            if (k < 70)
                req = 29'($urandom_range(0, 32'(cfg_pool) / 80 + 8));
            else if (k < 85)
                req = 29'($urandom_range(0, 32'(cfg_pool)));
            else if (k >= 93)
                case (k % 3)
                    0: req = cfg_pool;
                    1: req = cfg_pool - 29'd16;
                    default: req = '0;
                endcase
        end
        else if (pick < 90)
        begin
            cmd = CMD_RELEASE;
            if (granted.size() != 0 && k < 80)
            begin
                j   = $urandom_range(0, granted.size() - 1);
                rel = granted[j];
                if (k < 50)
                    granted.delete(j);
            end
            else if (granted.size() != 0 && k < 90)
            begin
                rel = granted[$] ^ (32'd1 << $urandom_range(0, 31));
            end
        end
        else if (pick < 96)
        begin
            cmd = CMD_CLEAR;
        end
        else
        begin
            cmd = CMD_SPARE;
        end
        push_word(cmd, req, rel, 1'b0, blank);
    endtask

    task automatic set_config(input logic [31:0] base, input logic [28:0] pool,
                              input bit put_base, input bit put_pool);
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (put_base)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_BASE;
            cfg_data  <= base;
            cfg_base   = base;
            @(posedge clk);
        end
        if (put_pool)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_POOL;
            cfg_data  <= {3'b0, pool};
            cfg_pool   = pool;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 99) < 25)
        begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap();
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (replies_due.size() == 0)
            begin
                $error("result word with none expected: status %0d address %h",
                       m_tdata[1:0], m_tdata[33:2]);
                faults++;
            end
            else
            begin
                head = replies_due.pop_front();
                if (m_tdata[1:0] !== head.status)
                begin
                    $error("status: expected %0d, got %0d", head.status, m_tdata[1:0]);
                    faults++;
                end
                if (m_tdata[33:2] !== head.address)
                begin
                    $error("address: expected %h, got %h", head.address, m_tdata[33:2]);
                    faults++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int          p;
        logic [31:0] bases [PHASES];
        logic [28:0] pools [PHASES];
        cfg_base = '0;
        cfg_pool = POOL_RESET;
        clear_table();
        bases = '{32'h0000_1000, 32'hFFFF_FFF0, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'h0, 32'h0, 32'h0, 32'h1C00_0000, 32'h0000_0100};
        pools = '{29'd4096, 29'h1FFF_FFFF, 29'd64, 29'd64, 29'd640,
                  29'd1200, 29'd0, 29'd0, 29'h40_0000, 29'd16777216};
        bases[5] = $urandom;
        bases[7] = $urandom;
        pools[7] = 29'($urandom);
        // Default pool of 16777216 bytes at address zero.
        script = '{
            {CMD_ALLOC,   29'd0,           32'd0,           1'b1, STATUS_OK,      32'd16},
            {CMD_ALLOC,   29'd1,           32'd0,           1'b1, STATUS_OK,      32'd32},
            {CMD_ALLOC,   29'd5,           32'd0,           1'b1, STATUS_OK,      32'd52},
            {CMD_RELEASE, 29'd0,           32'd32,          1'b1, STATUS_OK,      32'd0},
            {CMD_RELEASE, 29'd0,           32'd33,          1'b1, STATUS_UNKNOWN, 32'd0},
            {CMD_RELEASE, 29'd0,           32'd32,          1'b1, STATUS_OK,      32'd0},
            {CMD_SPARE,   29'h1FFF_FFFF,   32'hFFFF_FFFF,   1'b1, STATUS_OK,      32'd0},
            {CMD_ALLOC,   29'd4,           32'd0,           1'b0, STATUS_OK,      32'd0},
            {CMD_ALLOC,   29'd8,           32'd0,           1'b0, STATUS_OK,      32'd0},
            {CMD_ALLOC,   29'h1FFF_FFFF,   32'd0,           1'b1, STATUS_OOM,     32'd0},
            {CMD_ALLOC,   29'd16777216,    32'd0,           1'b1, STATUS_OK,      32'd16},
            {CMD_ALLOC,   29'd0,           32'd0,           1'b1, STATUS_OOM,     32'd0},
            {CMD_CLEAR,   29'h1555_5555,   32'hA5A5_5A5A,   1'b1, STATUS_OK,      32'd0},
            {CMD_RELEASE, 29'd0,           32'hFFFF_FFFF,   1'b1, STATUS_UNKNOWN, 32'd0},
            {CMD_RELEASE, 29'd0,           32'd16,          1'b1, STATUS_OK,      32'd0},
            {CMD_ALLOC,   29'd16777200,    32'd0,           1'b0, STATUS_OK,      32'd0},
            {CMD_CLEAR,   29'd0,           32'd0,           1'b1, STATUS_OK,      32'd0},
            {CMD_ALLOC,   29'd16777196,    32'd0,           1'b0, STATUS_OK,      32'd0},
            {CMD_ALLOC,   29'd4,           32'd0,           1'b0, STATUS_OK,      32'd0},
            {CMD_ALLOC,   29'd3,           32'h5A5A_A5A5,   1'b0, STATUS_OK,      32'd0}
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        foreach (script[i])
            push_word(script[i].cmd, script[i].req, script[i].rel, script[i].typed,
                      res_t'({script[i].status, script[i].address}));
        for (p = 0; p < PHASES; p++)
        begin
            calm = (p % 3 == 1);
            // Some phases change one register only, so the table outlives the new setting.
            set_config(bases[p], pools[p], p != 6, p != 3);
            repeat (PHASE_WORDS) random_word();
        end
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (faults == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
